// ===== hw/rtl/spring_pkg.sv =====
// Shared types and constants for the spring energy and force pipeline.
// Used by the square root cell, the divider cell and the top level.
package spring_pkg;

   localparam int SqrtCells = 33;
   localparam int DivCells  = 48;

   localparam logic [1:0] CSR_STIFFNESS    = 2'd0;
   localparam logic [1:0] CSR_REST_LENGTH  = 2'd1;
   localparam logic [1:0] CSR_MULTIPLICITY = 2'd2;

   localparam logic [31:0] STIFFNESS_RESET    = 32'h0001_0000;
   localparam logic [30:0] REST_LENGTH_RESET  = 31'h0001_0000;
   localparam logic [7:0]  MULTIPLICITY_RESET = 8'd1;

   // Data that walks down the square root chain.
   typedef struct packed {
      logic [65:0] rad;
      logic [33:0] rem;
      logic [32:0] root;
      logic [32:0] ax;
      logic [32:0] ay;
      logic        sx;
      logic        sy;
   } sqrt_data_type;

   // Data that walks down the divider chain, both force lanes side by side.
   typedef struct packed {
      logic [32:0] rem_x;
      logic [32:0] rem_y;
      logic [47:0] num_x;
      logic [47:0] num_y;
      logic [47:0] q_x;
      logic [47:0] q_y;
      logic [32:0] d;
      logic [47:0] energy;
      logic        sat_e;
      logic        zero;
      logic        neg_x;
      logic        neg_y;
      logic        ovf_x;
      logic        ovf_y;
   } div_data_type;

endpackage

// ===== hw/rtl/spring_energy_and_force_2d.sv =====
// Hookean spring energy and node A gradient for one spring per transfer.
// Throughput: one item per cycle while no stalled result blocks the pipeline; set by the
// 33-cell square root chain and the 48-cell divider chain, each cell handling one result bit per cycle.
// Reset clears all valid bits and loads the register reset values.
// Depends on spring_pkg, spring_sqrt_cell and spring_div_cell.
module spring_energy_and_force_2d import spring_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_node_a_x,
   input  logic signed [31:0] req_node_a_y,
   input  logic signed [31:0] req_node_b_x,
   input  logic signed [31:0] req_node_b_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [47:0]        rsp_energy,
   output logic signed [47:0] rsp_force_x,
   output logic signed [47:0] rsp_force_y,
   output logic               rsp_zero_length,
   output logic               rsp_saturated,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_write_data
);

   // Configuration.
   logic [31:0] stiffness_ff;
   logic [30:0] rest_length_ff;
   logic [7:0]  multiplicity_ff;
   logic [39:0] mk_ff;
   logic [39:0] mk_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         stiffness_ff    <= STIFFNESS_RESET;
         rest_length_ff  <= REST_LENGTH_RESET;
         multiplicity_ff <= MULTIPLICITY_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_STIFFNESS:    stiffness_ff    <= csr_write_data;
            CSR_REST_LENGTH:  rest_length_ff  <= csr_write_data[30:0];
            CSR_MULTIPLICITY: multiplicity_ff <= csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   assign mk_in = multiplicity_ff * stiffness_ff;

   always_ff @(posedge clock) begin
      mk_ff <= mk_in;
   end

   // Pipeline advance: everything moves unless a stalled result blocks a full tail.
   logic adv;
   logic div_last_v;

   assign adv       = !rsp_valid || !rsp_stall || !div_last_v;
   assign req_stall = !adv;

   // Front stages: differences, magnitudes, squares, sum.
   logic        v1_ff, v2_ff, v3_ff, v4_ff;
   logic [32:0] dx_ff, dy_ff;
   logic [32:0] ax2_ff, ay2_ff, ax3_ff, ay3_ff, ax4_ff, ay4_ff;
   logic        sx2_ff, sy2_ff, sx3_ff, sy3_ff, sx4_ff, sy4_ff;
   logic [65:0] sqx_ff, sqy_ff, sum_ff;
   logic [32:0] dx_in, dy_in;

   assign dx_in = {req_node_a_x[31], req_node_a_x} - {req_node_b_x[31], req_node_b_x};
   assign dy_in = {req_node_a_y[31], req_node_a_y} - {req_node_b_y[31], req_node_b_y};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dx_ff  <= dx_in;
         dy_ff  <= dy_in;
         ax2_ff <= dx_ff[32] ? 33'(-dx_ff) : dx_ff;
         ay2_ff <= dy_ff[32] ? 33'(-dy_ff) : dy_ff;
         sx2_ff <= dx_ff[32];
         sy2_ff <= dy_ff[32];
         sqx_ff <= ax2_ff * ax2_ff;
         sqy_ff <= ay2_ff * ay2_ff;
         ax3_ff <= ax2_ff;
         ay3_ff <= ay2_ff;
         sx3_ff <= sx2_ff;
         sy3_ff <= sy2_ff;
         sum_ff <= sqx_ff + sqy_ff;
         ax4_ff <= ax3_ff;
         ay4_ff <= ay3_ff;
         sx4_ff <= sx3_ff;
         sy4_ff <= sy3_ff;
      end
   end

   // Square root chain.
   sqrt_data_type sq_d [0:SqrtCells];
   logic          sq_v [0:SqrtCells];

   always_comb begin
      sq_d[0].rad  = sum_ff;
      sq_d[0].rem  = '0;
      sq_d[0].root = '0;
      sq_d[0].ax   = ax4_ff;
      sq_d[0].ay   = ay4_ff;
      sq_d[0].sx   = sx4_ff;
      sq_d[0].sy   = sy4_ff;
   end
   assign sq_v[0] = v4_ff;

   for (genvar i = 0; i < SqrtCells; i++) begin : g_sqrt
      spring_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (sq_v[i]),
         .in_data   (sq_d[i]),
         .out_valid (sq_v[i+1]),
         .out_data  (sq_d[i+1])
      );
   end

   // Back stages: length error, products, scaling by m*k, divider setup.
   logic         p1_v_ff, p2_v_ff, p3_v_ff, p4_v_ff, p5_v_ff;
   logic [33:0]  diff;
   logic [32:0]  dmag_ff, ax_p1_ff, ay_p1_ff;
   logic [32:0]  d1_ff, d2_ff, d3_ff, d4_ff;
   logic         dneg1_ff, sx1_ff, sy1_ff, z1_ff;
   logic         dneg2_ff, sx2b_ff, sy2b_ff, z2_ff;
   logic         dneg3_ff, sx3b_ff, sy3b_ff, z3_ff;
   logic         dneg4_ff, sx4b_ff, sy4b_ff, z4_ff;
   logic [65:0]  e2_ff, nx_ff, ny_ff;
   logic [72:0]  elo_ff, ehi_ff, xlo_ff, xhi_ff, ylo_ff, yhi_ff;
   logic [105:0] pe_ff, px_ff, py_ff;
   logic [89:0]  nxs, nys;
   div_data_type dv_init_ff;
   div_data_type dv_init_in;

   assign diff = {1'b0, sq_d[SqrtCells].root} - {3'b000, rest_length_ff};
   assign nxs  = px_ff[105:16];
   assign nys  = py_ff[105:16];

   always_comb begin
      dv_init_in.rem_x  = nxs[80:48];
      dv_init_in.rem_y  = nys[80:48];
      dv_init_in.num_x  = nxs[47:0];
      dv_init_in.num_y  = nys[47:0];
      dv_init_in.q_x    = '0;
      dv_init_in.q_y    = '0;
      dv_init_in.d      = d4_ff;
      dv_init_in.sat_e  = |pe_ff[105:81];
      dv_init_in.energy = dv_init_in.sat_e ? '1 : pe_ff[80:33];
      dv_init_in.zero   = z4_ff;
      dv_init_in.neg_x  = dneg4_ff ^ sx4b_ff;
      dv_init_in.neg_y  = dneg4_ff ^ sy4b_ff;
      // A quotient of 2^48 or more is certain to clip.
      dv_init_in.ovf_x  = nxs[89:48] >= {9'd0, d4_ff};
      dv_init_in.ovf_y  = nys[89:48] >= {9'd0, d4_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
         p3_v_ff <= 1'b0;
         p4_v_ff <= 1'b0;
         p5_v_ff <= 1'b0;
      end else if (adv) begin
         p1_v_ff <= sq_v[SqrtCells];
         p2_v_ff <= p1_v_ff;
         p3_v_ff <= p2_v_ff;
         p4_v_ff <= p3_v_ff;
         p5_v_ff <= p4_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dmag_ff  <= diff[33] ? 33'(-diff) : diff[32:0];
         dneg1_ff <= diff[33];
         d1_ff    <= sq_d[SqrtCells].root;
         z1_ff    <= sq_d[SqrtCells].root == '0;
         ax_p1_ff <= sq_d[SqrtCells].ax;
         ay_p1_ff <= sq_d[SqrtCells].ay;
         sx1_ff   <= sq_d[SqrtCells].sx;
         sy1_ff   <= sq_d[SqrtCells].sy;

         e2_ff    <= dmag_ff * dmag_ff;
         nx_ff    <= dmag_ff * ax_p1_ff;
         ny_ff    <= dmag_ff * ay_p1_ff;
         d2_ff    <= d1_ff;
         dneg2_ff <= dneg1_ff;
         z2_ff    <= z1_ff;
         sx2b_ff  <= sx1_ff;
         sy2b_ff  <= sy1_ff;

         elo_ff   <= e2_ff[32:0] * mk_ff;
         ehi_ff   <= e2_ff[65:33] * mk_ff;
         xlo_ff   <= nx_ff[32:0] * mk_ff;
         xhi_ff   <= nx_ff[65:33] * mk_ff;
         ylo_ff   <= ny_ff[32:0] * mk_ff;
         yhi_ff   <= ny_ff[65:33] * mk_ff;
         d3_ff    <= d2_ff;
         dneg3_ff <= dneg2_ff;
         z3_ff    <= z2_ff;
         sx3b_ff  <= sx2b_ff;
         sy3b_ff  <= sy2b_ff;

         pe_ff    <= {33'd0, elo_ff} + {ehi_ff, 33'd0};
         px_ff    <= {33'd0, xlo_ff} + {xhi_ff, 33'd0};
         py_ff    <= {33'd0, ylo_ff} + {yhi_ff, 33'd0};
         d4_ff    <= d3_ff;
         dneg4_ff <= dneg3_ff;
         z4_ff    <= z3_ff;
         sx4b_ff  <= sx3b_ff;
         sy4b_ff  <= sy3b_ff;

         dv_init_ff <= dv_init_in;
      end
   end

   // Divider chain.
   div_data_type dv_d [0:DivCells];
   logic         dv_v [0:DivCells];

   assign dv_d[0] = dv_init_ff;
   assign dv_v[0] = p5_v_ff;

   for (genvar j = 0; j < DivCells; j++) begin : g_div
      spring_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (dv_v[j]),
         .in_data   (dv_d[j]),
         .out_valid (dv_v[j+1]),
         .out_data  (dv_d[j+1])
      );
   end

   assign div_last_v = dv_v[DivCells];

   // Output register: clip the quotients and apply signs.
   div_data_type last;
   logic [47:0]  lim_x, lim_y, mag_x, mag_y, fx_in, fy_in;
   logic         satx, saty, sat_in;
   logic         out_load;
   logic         rsp_valid_ff;
   logic [47:0]  energy_ff, fx_ff, fy_ff;
   logic         zero_ff, sat_ff;

   assign last = dv_d[DivCells];

   always_comb begin
      lim_x  = last.neg_x ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
      lim_y  = last.neg_y ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
      satx   = !last.zero && (last.ovf_x || last.q_x > lim_x);
      saty   = !last.zero && (last.ovf_y || last.q_y > lim_y);
      mag_x  = satx ? lim_x : last.q_x;
      mag_y  = saty ? lim_y : last.q_y;
      fx_in  = last.zero ? '0 : (last.neg_x ? 48'(-mag_x) : mag_x);
      fy_in  = last.zero ? '0 : (last.neg_y ? 48'(-mag_y) : mag_y);
      sat_in = last.sat_e || satx || saty;
   end

   assign out_load = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= div_last_v;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         energy_ff <= last.energy;
         fx_ff     <= fx_in;
         fy_ff     <= fy_in;
         zero_ff   <= last.zero;
         sat_ff    <= sat_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_energy      = energy_ff;
   assign rsp_force_x     = fx_ff;
   assign rsp_force_y     = fy_ff;
   assign rsp_zero_length = zero_ff;
   assign rsp_saturated   = sat_ff;

`ifndef SYNTHESIS
   a_zero_force : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_length |-> rsp_force_x == '0 && rsp_force_y == '0)
      else $error("force not zero for coinciding nodes");

   a_input_flow : assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && rsp_stall) |-> !req_stall)
      else $error("input stalled while output can move");

   a_hold_result : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_energy))
      else $error("stalled result lost");
`endif

endmodule

// ===== hw/rtl/spring_sqrt_cell.sv =====
// One bit of the restoring integer square root chain.
// Depends on spring_pkg for the data type that moves between cells.
module spring_sqrt_cell import spring_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  logic          in_valid,
   input  sqrt_data_type in_data,
   output logic          out_valid,
   output sqrt_data_type out_data
);

   logic          valid_ff;
   logic          valid_in;
   sqrt_data_type data_ff;
   sqrt_data_type data_in;
   logic [35:0]   rem_sh;
   logic [35:0]   trial;

   always_comb begin
      data_in     = in_data;
      rem_sh      = {in_data.rem, in_data.rad[65:64]};
      trial       = {1'b0, in_data.root, 2'b01};
      data_in.rad = {in_data.rad[63:0], 2'b00};
      if (rem_sh >= trial) begin
         data_in.rem  = 34'(rem_sh - trial);
         data_in.root = {in_data.root[31:0], 1'b1};
      end else begin
         data_in.rem  = rem_sh[33:0];
         data_in.root = {in_data.root[31:0], 1'b0};
      end
      valid_in = adv ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== hw/rtl/spring_div_cell.sv =====
// One quotient bit of the restoring divider chain, x and y lanes together.
// Depends on spring_pkg for the data type that moves between cells.
module spring_div_cell import spring_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         adv,
   input  logic         in_valid,
   input  div_data_type in_data,
   output logic         out_valid,
   output div_data_type out_data
);

   logic         valid_ff;
   logic         valid_in;
   div_data_type data_ff;
   div_data_type data_in;
   logic [33:0]  part_x;
   logic [33:0]  part_y;
   logic [33:0]  dvs;

   always_comb begin
      data_in       = in_data;
      dvs           = {1'b0, in_data.d};
      part_x        = {in_data.rem_x, in_data.num_x[47]};
      part_y        = {in_data.rem_y, in_data.num_y[47]};
      data_in.num_x = {in_data.num_x[46:0], 1'b0};
      data_in.num_y = {in_data.num_y[46:0], 1'b0};
      if (part_x >= dvs) begin
         data_in.rem_x = 33'(part_x - dvs);
         data_in.q_x   = {in_data.q_x[46:0], 1'b1};
      end else begin
         data_in.rem_x = part_x[32:0];
         data_in.q_x   = {in_data.q_x[46:0], 1'b0};
      end
      if (part_y >= dvs) begin
         data_in.rem_y = 33'(part_y - dvs);
         data_in.q_y   = {in_data.q_y[46:0], 1'b1};
      end else begin
         data_in.rem_y = part_y[32:0];
         data_in.q_y   = {in_data.q_y[46:0], 1'b0};
      end
      valid_in = adv ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the 2D spring energy and force pipeline.
// Holds its own bit-exact predictor in a small scoreboard class.
// Depends on spring_pkg and spring_energy_and_force_2d.
module tb_top import spring_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam logic [47:0] POS_CLIP = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0] NEG_CLIP = 48'h8000_0000_0000;

   typedef struct {
      logic [47:0] energy;
      logic [47:0] force_x;
      logic [47:0] force_y;
      logic        zero_length;
      logic        saturated;
   } spring_result_type;

   class spring_scoreboard_type;
      logic [31:0] stiffness = STIFFNESS_RESET;
      logic [30:0] rest_length = REST_LENGTH_RESET;
      logic [7:0]  multiplicity = MULTIPLICITY_RESET;
      spring_result_type expected_q[$];
      int errors = 0;

      function void write_reg(logic [1:0] index, logic [31:0] data);
         case (index)
            CSR_STIFFNESS: stiffness = data;
            CSR_REST_LENGTH: rest_length = data[30:0];
            CSR_MULTIPLICITY: multiplicity = data[7:0];
            default: ;
         endcase
      endfunction

      // One gradient component: m*k*|d-L0|*|c| / (d << 16), truncated, signed.
      function logic [47:0] gradient(logic [33:0] stretch, logic stretch_neg,
                                     logic [32:0] comp, logic comp_neg,
                                     logic [32:0] spring_len, inout logic sat);
         logic [127:0] num;
         logic [127:0] quo;
         logic [127:0] limit;
         logic         neg;
         num = 128'(stretch) * 128'(comp) * 128'(stiffness) * 128'(multiplicity);
         quo = num / (128'(spring_len) << 16);
         neg = stretch_neg != comp_neg;
         limit = neg ? 128'(NEG_CLIP) : 128'(POS_CLIP);
         if (quo > limit) begin
            quo = limit;
            sat = 1'b1;
         end
         return neg ? 48'(-quo) : 48'(quo);
      endfunction

      function void note(logic signed [31:0] ax, logic signed [31:0] ay,
                         logic signed [31:0] bx, logic signed [31:0] by);
         logic signed [32:0] dx;
         logic signed [32:0] dy;
         logic [32:0]        mx;
         logic [32:0]        my;
         logic [65:0]        sq;
         logic [32:0]        spring_len;
         logic [32:0]        trial;
         logic signed [34:0] diff;
         logic [33:0]        stretch;
         logic [127:0]       p;
         spring_result_type  r;
         dx = {ax[31], ax} - {bx[31], bx};
         dy = {ay[31], ay} - {by[31], by};
         mx = dx[32] ? 33'(-dx) : 33'(dx);
         my = dy[32] ? 33'(-dy) : 33'(dy);
         sq = 66'(mx) * 66'(mx) + 66'(my) * 66'(my);
         spring_len = '0;
         for (int b = 32; b >= 0; b--) begin
            trial = spring_len | (33'd1 << b);
            if (66'(trial) * 66'(trial) <= sq) spring_len = trial;
         end
         diff = $signed({2'b00, spring_len}) - $signed({4'b0000, rest_length});
         stretch = diff[34] ? 34'(-diff) : 34'(diff);
         p = 128'(stretch) * 128'(stretch) * 128'(stiffness) * 128'(multiplicity);
         r.saturated = 1'b0;
         r.energy = p[80:33];
         if (p[127:81] != '0) begin
            r.energy = '1;
            r.saturated = 1'b1;
         end
         r.zero_length = (spring_len == '0);
         r.force_x = '0;
         r.force_y = '0;
         if (spring_len != '0) begin
            r.force_x = gradient(stretch, diff[34], mx, dx[32], spring_len, r.saturated);
            r.force_y = gradient(stretch, diff[34], my, dy[32], spring_len, r.saturated);
         end
         expected_q.push_back(r);
      endfunction

      function void compare(string field, logic [47:0] exp_v, logic [47:0] act_v);
         if (exp_v !== act_v) begin
            errors++;
            $display("%0t %s mismatch: expected %h actual %h", $time, field, exp_v, act_v);
         end
      endfunction

      function void check(spring_result_type act);
         spring_result_type exp_r;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t unexpected result: expected none actual energy %h",
                     $time, act.energy);
            return;
         end
         exp_r = expected_q.pop_front();
         compare("energy", exp_r.energy, act.energy);
         compare("force_x", exp_r.force_x, act.force_x);
         compare("force_y", exp_r.force_y, act.force_y);
         compare("zero_length", 48'(exp_r.zero_length), 48'(act.zero_length));
         compare("saturated", 48'(exp_r.saturated), 48'(act.saturated));
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_node_a_x = '0;
   logic signed [31:0] req_node_a_y = '0;
   logic signed [31:0] req_node_b_x = '0;
   logic signed [31:0] req_node_b_y = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [47:0]        rsp_energy;
   logic signed [47:0] rsp_force_x;
   logic signed [47:0] rsp_force_y;
   logic               rsp_zero_length;
   logic               rsp_saturated;
   logic               csr_write_enable = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [31:0]        csr_write_data = '0;

   spring_scoreboard_type spring_sb = new();
   bit tx_burst = 0;
   bit rx_burst = 0;
   bit hold_request = 0;

   spring_energy_and_force_2d u_dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("tb_top: errors");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write_enable) spring_sb.write_reg(csr_index, csr_write_data);
         if (req_valid && !req_stall)
            spring_sb.note(req_node_a_x, req_node_a_y, req_node_b_x, req_node_b_y);
         if (rsp_valid && !rsp_stall)
            spring_sb.check('{rsp_energy, rsp_force_x, rsp_force_y,
                              rsp_zero_length, rsp_saturated});
      end
   end

   // Result side: random stall before each transfer outside bursts, plus one long hold-off.
   initial begin
      int wait_cycles;
      @(negedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 0;
            rsp_stall <= 1'b1;
            repeat (400) @(negedge clock);
         end
         wait_cycles = rx_burst ? 0 : $urandom_range(0, 13);
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   task automatic send_spring(logic [31:0] ax, logic [31:0] ay,
                              logic [31:0] bx, logic [31:0] by);
      int gap;
      gap = tx_burst ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_node_a_x <= ax;
      req_node_a_y <= ay;
      req_node_b_x <= bx;
      req_node_b_y <= by;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Stops offering items and waits until every expected result has arrived.
   task automatic drain();
      req_valid <= 1'b0;
      while (spring_sb.expected_q.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   task automatic csr_write(logic [1:0] index, logic [31:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_spring(logic [31:0] k, logic [31:0] len, logic [31:0] m);
      csr_write(CSR_STIFFNESS, k);
      csr_write(CSR_REST_LENGTH, len);
      csr_write(CSR_MULTIPLICITY, m);
   endtask

   task automatic random_springs(int count, bit long_hold);
      logic [31:0] ax;
      logic [31:0] ay;
      logic [31:0] bx;
      logic [31:0] by;
      int          span;
      for (int i = 0; i < count; i++) begin
         if (i % 50 == 0) begin
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
         end
         if (long_hold && i == count / 2) begin
            tx_burst = 1;
            hold_request = 1;
         end
         ax = $urandom();
         ay = $urandom();
         span = $urandom_range(0, 9);
         if (span == 0) begin
            bx = ax;
            by = ay;
         end else if (span <= 6) begin
            // Nearby nodes keep stretches and forces within range.
            bx = ax + $urandom_range(0, 1 << (12 + span * 2)) - (1 << (11 + span * 2));
            by = ay + $urandom_range(0, 1 << (12 + span * 2)) - (1 << (11 + span * 2));
         end else if (span == 9) begin
            bx = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            by = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         end else begin
            bx = $urandom();
            by = $urandom();
         end
         send_spring(ax, ay, bx, by);
      end
      tx_burst = 0;
      rx_burst = 0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed items at reset settings: extremes, coincident nodes, exact rest length.
      send_spring(32'h0, 32'h0, 32'h0, 32'h0);
      send_spring(32'h1234_5678, 32'h8765_4321, 32'h1234_5678, 32'h8765_4321);
      send_spring(32'h0001_0000, 32'h0, 32'h0, 32'h0);
      send_spring(32'h0, 32'h0001_0000, 32'h0, 32'h0);
      send_spring(32'h0, 32'h0, 32'h0001_8000, 32'hFFFF_0000);
      send_spring(32'h0000_4000, 32'h0, 32'h0, 32'h0000_4000);
      send_spring(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
      send_spring(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_spring(32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h0);
      send_spring(32'h0, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF);
      send_spring(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
      send_spring(32'h0003_0000, 32'hFFFC_0000, 32'h0, 32'h0);
      drain();

      // Largest stiffness, rest length and multiplicity; rest length bit 31 is masked.
      set_spring(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFF);
      csr_write(CSR_UNUSED, 32'hDEAD_BEEF);
      send_spring(32'h0, 32'h0, 32'h0, 32'h0);
      send_spring(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
      send_spring(32'h0001_0000, 32'h0, 32'h0, 32'h0);
      send_spring(32'h0, 32'h0, 32'h0, 32'h8000_0000);
      drain();

      // Zero multiplicity and zero stiffness clear energy and forces.
      set_spring(32'h0003_0000, 32'h0, 32'h0);
      send_spring(32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h0);
      send_spring(32'h0, 32'h0, 32'h0, 32'h0);
      drain();
      set_spring(32'h0, 32'h0002_0000, 32'h3);
      send_spring(32'h0005_0000, 32'h0, 32'h0, 32'h0);
      drain();

      set_spring(32'h0001_0000, 32'h0001_0000, 32'h1);
      random_springs(450, 1);
      drain();
      set_spring(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFF);
      random_springs(400, 0);
      drain();
      set_spring(32'h0, 32'h0, 32'h1);
      random_springs(100, 0);
      drain();
      set_spring($urandom(), $urandom_range(0, 32'h0010_0000), $urandom_range(1, 255));
      random_springs(450, 0);
      drain();
      set_spring($urandom_range(0, 32'h0004_0000), 32'h0, $urandom_range(1, 16));
      csr_write(CSR_UNUSED, $urandom());
      random_springs(450, 0);
      drain();

      if (spring_sb.errors == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end
endmodule
